FILE: src/fida_pkg.sv
// Shared types and constants of the identifier allocator.
`timescale 1ns / 1ps
`default_nettype none

package fida_pkg;

  // Width of the identifier fields on the stream ports.
  localparam int unsigned ReqIdW = 10;
  // tdata width: identifier field padded to whole bytes.
  localparam int unsigned TdataW = 16;
  localparam int unsigned StatusW = 2;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE       = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_e;

endpackage

`default_nettype wire

FILE: src/fida_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fida_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/fifo_id_allocator_core.sv
// Top level of the free-list identifier allocator.
`timescale 1ns / 1ps
`default_nettype none

// Identifier allocator built around a free queue. After reset the free queue
// holds identifiers 0 to ID_SLOTS-1 in order, and no identifier is in use. An
// allocate transaction (tuser = 0) takes the oldest free identifier, marks it
// in use and returns it with status done; on an empty pool it returns zero
// with status empty. A release transaction (tuser = 1) returns release_id to
// the back of the free queue if it is in use and answers done; otherwise it
// changes nothing and answers not-in-use. Every request gives exactly one
// result. A request first reads the free queue and the in-use map, which are
// synchronous memories, and is then decided, written back and loaded into
// the output register. A new request is taken in the cycle after the
// previous one was written back, so the memories never see a read and a write
// of the same entry in flight together. The output register lets a finished
// result wait for the consumer while the next request is read. No clearing
// pass is needed after reset: an entry of the free queue that the tail has
// not yet reached reads as its own index, and an in-use bit of an identifier
// that the head has not yet handed out reads as clear.
module fifo_id_allocator_core
  import fida_pkg::*;
#(
  parameter int unsigned ID_SLOTS = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Request stream.
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [TdataW-1:0] s_axis_tdata_i,   // [9:0] release_id, rest zero
  input  wire logic              s_axis_tuser_i,   // [0] operation
  // Result stream.
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [TdataW-1:0]      m_axis_tdata_o,   // [9:0] granted_id, rest zero
  output logic [StatusW-1:0]     m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned IdW  = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(ID_SLOTS + 1);
  // Width that holds both a pool identifier and a request identifier.
  localparam int unsigned XW   = (IdW > ReqIdW) ? IdW : ReqIdW;

  localparam logic [IdW-1:0]  LastIdx  = IdW'(ID_SLOTS - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(ID_SLOTS);

  // Request held from acceptance until write-back.
  logic              busy_q;
  op_e               op_q;
  logic [ReqIdW-1:0] rid_q;

  // Queue pointers and fill state.
  logic [IdW-1:0]  head_q, head_d;
  logic [IdW-1:0]  tail_q, tail_d;
  logic            head_wrap_q, head_wrap_d;
  logic            tail_wrap_q, tail_wrap_d;
  logic [CntW-1:0] count_q, count_d;

  // Output register.
  logic                m_valid_q;
  logic [ReqIdW-1:0]   m_id_q, m_id_d;
  status_e             m_status_q, m_status_d;

  logic              accept;
  logic              complete;
  logic [XW-1:0]     in_rid_x;
  logic [XW-1:0]     req_rid_x;
  logic [IdW-1:0]    req_idx;
  logic              req_in_range;
  logic [IdW-1:0]    queue_rdata;
  logic              map_rdata;
  logic [IdW-1:0]    alloc_id;
  logic [XW-1:0]     alloc_id_x;
  logic              map_seen;
  logic              in_use;
  logic              can_alloc;
  logic              can_release;
  logic [IdW-1:0]    head_inc;
  logic [IdW-1:0]    tail_inc;
  logic              queue_we;
  logic              map_we;
  logic [IdW-1:0]    map_waddr;

  // One request at a time; the output register decouples the consumer.
  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign complete        = busy_q && (!m_valid_q || m_axis_tready_i);

  assign in_rid_x  = XW'(s_axis_tdata_i[ReqIdW-1:0]);
  assign req_rid_x = XW'(rid_q);
  assign req_idx   = req_rid_x[IdW-1:0];
  // An identifier at or above the pool size is never in use.
  assign req_in_range = (32'(rid_q) < 32'(ID_SLOTS));

  // Entries the tail has not written yet still hold their reset contents.
  assign alloc_id   = (tail_wrap_q || (head_q < tail_q)) ? queue_rdata : head_q;
  assign alloc_id_x = XW'(alloc_id);

  // Only identifiers the head has already passed can have a stored bit.
  assign map_seen = head_wrap_q || (req_idx < head_q);
  assign in_use   = req_in_range && map_seen && map_rdata;

  assign can_alloc   = (count_q != '0);
  assign can_release = in_use && (count_q != FullCnt);

  assign head_inc = (head_q == LastIdx) ? '0 : head_q + IdW'(1);
  assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + IdW'(1);

  assign queue_we  = complete && (op_q == OP_RELEASE) && can_release;
  assign map_we    = complete && (((op_q == OP_ALLOC) && can_alloc) ||
                                  ((op_q == OP_RELEASE) && can_release));
  assign map_waddr = (op_q == OP_ALLOC) ? alloc_id : req_idx;

  fida_ram #(
    .DEPTH (ID_SLOTS),
    .WIDTH (IdW)
  ) u_free_queue (
    .clk_i   (clk_i),
    .we_i    (queue_we),
    .waddr_i (tail_q),
    .wdata_i (req_idx),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (queue_rdata)
  );

  fida_ram #(
    .DEPTH (ID_SLOTS),
    .WIDTH (1)
  ) u_in_use_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (op_q == OP_ALLOC),
    .re_i    (accept),
    .raddr_i (in_rid_x[IdW-1:0]),
    .rdata_o (map_rdata)
  );

  // Pointer, count and result computation for the request being written back.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    head_wrap_d = head_wrap_q;
    tail_wrap_d = tail_wrap_q;
    count_d     = count_q;
    m_id_d      = '0;
    m_status_d  = ST_DONE;
    unique case (op_q)
      OP_ALLOC: begin
        if (can_alloc) begin
          head_d  = head_inc;
          count_d = count_q - CntW'(1);
          m_id_d  = alloc_id_x[ReqIdW-1:0];
          if (head_q == LastIdx) begin
            head_wrap_d = 1'b1;
          end
        end else begin
          m_status_d = ST_EMPTY;
        end
      end
      OP_RELEASE: begin
        if (can_release) begin
          tail_d  = tail_inc;
          count_d = count_q + CntW'(1);
          if (tail_q == LastIdx) begin
            tail_wrap_d = 1'b1;
          end
        end else begin
          m_status_d = ST_NOT_IN_USE;
        end
      end
      default: begin
        m_status_d = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      head_wrap_q <= 1'b0;
      tail_wrap_q <= 1'b0;
      count_q     <= FullCnt;
      m_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (complete) begin
        busy_q <= 1'b0;
      end
      if (complete) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        head_wrap_q <= head_wrap_d;
        tail_wrap_q <= tail_wrap_d;
        count_q     <= count_d;
        m_valid_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(s_axis_tuser_i);
      rid_q <= s_axis_tdata_i[ReqIdW-1:0];
    end
    if (complete) begin
      m_id_q     <= m_id_d;
      m_status_q <= m_status_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TdataW'(m_id_q);
  assign m_axis_tuser_o  = m_status_q;

endmodule

`default_nettype wire

FILE: src/fida_checker.sv
// Port-level checker for the identifier allocator and its bind.
`timescale 1ns / 1ps
`default_nettype none

module fida_checker
  import fida_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_tvalid_i,
  input wire logic               s_tready_i,
  input wire logic               m_tvalid_i,
  input wire logic               m_tready_i,
  input wire logic [TdataW-1:0]  m_tdata_i,
  input wire logic [StatusW-1:0] m_tuser_i
);

  // Requests are handled one at a time, so the port closes after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("request port stayed open after a transaction");

  // A result that rises on an idle output comes from an accepted request whose
  // memory read was followed by write-back and the load of the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_i) |-> $past(s_tvalid_i && s_tready_i, 2))
    else $error("result appeared without a request two edges earlier");

  // Failed requests carry no identifier; releases also return zero, but only failures are asserted here.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i != ST_DONE) |-> (m_tdata_i == '0))
    else $error("failed request returned a nonzero identifier");

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("stalled result changed");

endmodule

bind fifo_id_allocator_core fida_checker u_fida_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
